### sv/dilp_pkg.sv
package dilp_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_SEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_EN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M1_RULE   = 2'd3;

  localparam logic [7:0] GROUP_SEP_RST = 8'h7C;
  localparam logic [7:0] FIELD_SEP_RST = 8'h2C;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    MT_START,
    MT_DASH,
    MT_MINUS_ONE,
    MT_OTHER
  } track_t;

  typedef struct packed {
    logic [7:0] group_sep;
    logic [7:0] field_sep;
    logic       split_en;
    logic       m1_rule;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] number;
    logic               number_valid;
    logic               group_done;
    logic               text_done;
  } res_t;

  localparam res_t END_MARKER = '{number: 32'sd0, number_valid: 1'b0,
                                  group_done: 1'b0, text_done: 1'b1};

  function automatic logic [1:0] inc3(input logic [1:0] p);
    inc3 = (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  function automatic logic signed [31:0] field_val(input logic neg, input logic [31:0] mag);
    if (neg) begin
      field_val = $signed(32'd0 - mag);
    end else begin
      field_val = $signed((mag > POS_MAX) ? POS_MAX : mag);
    end
  endfunction

endpackage

### sv/dilp_step.sv
module dilp_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  input  dilp_pkg::cfg_t      cfg,
  output dilp_pkg::res_t      res0,
  output dilp_pkg::res_t      res1,
  output logic [1:0]          res_cnt
);
  import dilp_pkg::*;

  logic [31:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  phase_t      phase_r, phase_nxt;
  logic        ghb_r, ghb_nxt;
  logic        halted_r, halted_nxt;
  track_t      track_r, track_nxt;

  logic [31:0] mag_f;
  logic        neg_f;
  phase_t      phase_f;
  logic [35:0] mag_x10;
  logic        is_digit, is_space, go;

  // digit accumulate and whitespace/sign handling for the current byte
  always_comb begin
    is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    is_space = (text_byte == CH_SPACE) || ((text_byte >= CH_TAB) && (text_byte <= CH_CR));
    mag_x10  = {1'b0, mag_r, 3'b000} + {3'b000, mag_r, 1'b0}
             + {32'd0, text_byte[3:0]};
    mag_f    = mag_r;
    neg_f    = neg_r;
    phase_f  = phase_r;
    go       = 1'b0;
    case (phase_r)
      PH_SKIP: begin
        if (is_space) begin
          phase_f = PH_SKIP;
        end else if ((text_byte == CH_PLUS) || (text_byte == CH_MINUS)) begin
          neg_f   = (text_byte == CH_MINUS);
          phase_f = PH_DIGITS;
        end else begin
          phase_f = PH_DIGITS;
          go      = 1'b1;
        end
      end
      PH_DIGITS: go = 1'b1;
      default:   go = 1'b0;
    endcase
    if (go) begin
      if (is_digit) begin
        mag_f = (mag_x10 > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : mag_x10[31:0];
      end else begin
        phase_f = PH_DONE;
      end
    end
  end

  always_comb begin
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    phase_nxt  = phase_r;
    ghb_nxt    = ghb_r;
    halted_nxt = halted_r;
    track_nxt  = track_r;
    res0       = '0;
    res1       = '0;
    res_cnt    = 2'd0;
    if (halted_r) begin
      if (end_of_text) begin
        res0       = END_MARKER;
        res_cnt    = 2'd1;
        halted_nxt = 1'b0;
        ghb_nxt    = 1'b0;
        track_nxt  = MT_START;
        mag_nxt    = '0;
        neg_nxt    = 1'b0;
        phase_nxt  = PH_SKIP;
      end
    end else begin
      case (track_r)
        MT_START: track_nxt = (text_byte == CH_MINUS) ? MT_DASH : MT_OTHER;
        MT_DASH:  track_nxt = (text_byte == CH_ONE) ? MT_MINUS_ONE : MT_OTHER;
        default:  track_nxt = MT_OTHER;
      endcase
      if (end_of_text && cfg.m1_rule && (track_nxt == MT_MINUS_ONE)) begin
        res0    = END_MARKER;
        res_cnt = 2'd1;
      end else if (text_byte == cfg.group_sep) begin
        mag_nxt   = '0;
        neg_nxt   = 1'b0;
        phase_nxt = PH_SKIP;
        if (!ghb_r) begin
          halted_nxt = 1'b1;
          if (end_of_text) begin
            res0    = END_MARKER;
            res_cnt = 2'd1;
          end
        end else begin
          res0    = '{number: field_val(neg_r, mag_r), number_valid: 1'b1,
                      group_done: 1'b1, text_done: 1'b0};
          ghb_nxt = 1'b0;
          res_cnt = 2'd1;
          if (end_of_text) begin
            res1    = END_MARKER;
            res_cnt = 2'd2;
          end
        end
      end else if (cfg.split_en && (text_byte == cfg.field_sep)) begin
        res0      = '{number: field_val(neg_r, mag_r), number_valid: 1'b1,
                      group_done: 1'b0, text_done: 1'b0};
        res_cnt   = 2'd1;
        mag_nxt   = '0;
        neg_nxt   = 1'b0;
        phase_nxt = PH_SKIP;
        ghb_nxt   = 1'b1;
        if (end_of_text) begin
          res1    = '{number: 32'sd0, number_valid: 1'b1,
                      group_done: 1'b1, text_done: 1'b1};
          res_cnt = 2'd2;
        end
      end else begin
        ghb_nxt   = 1'b1;
        mag_nxt   = mag_f;
        neg_nxt   = neg_f;
        phase_nxt = phase_f;
        if (end_of_text) begin
          res0    = '{number: field_val(neg_f, mag_f), number_valid: 1'b1,
                      group_done: 1'b1, text_done: 1'b1};
          res_cnt = 2'd1;
        end
      end
      if (end_of_text) begin
        mag_nxt    = '0;
        neg_nxt    = 1'b0;
        phase_nxt  = PH_SKIP;
        ghb_nxt    = 1'b0;
        halted_nxt = 1'b0;
        track_nxt  = MT_START;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r    <= '0;
      neg_r    <= 1'b0;
      phase_r  <= PH_SKIP;
      ghb_r    <= 1'b0;
      halted_r <= 1'b0;
      track_r  <= MT_START;
    end else if (accept) begin
      mag_r    <= mag_nxt;
      neg_r    <= neg_nxt;
      phase_r  <= phase_nxt;
      ghb_r    <= ghb_nxt;
      halted_r <= halted_nxt;
      track_r  <= track_nxt;
    end
  end

endmodule

### sv/dilp_resq.sv
module dilp_resq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  logic [1:0]     push_cnt,
  input  dilp_pkg::res_t push0,
  input  dilp_pkg::res_t push1,
  output logic           room,
  output logic           q_valid,
  input  logic           q_ready,
  output dilp_pkg::res_t q_head
);
  import dilp_pkg::*;

  res_t       mem_r [3];
  logic [1:0] wr_r, wr_nxt;
  logic [1:0] rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [1:0] n_in;
  logic       pop;

  assign room    = !cnt_r[1];
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = mem_r[rd_r];
  assign pop     = q_valid && q_ready;

  always_comb begin
    n_in    = push ? push_cnt : 2'd0;
    wr_nxt  = wr_r;
    case (n_in)
      2'd1:    wr_nxt = inc3(wr_r);
      2'd2:    wr_nxt = inc3(inc3(wr_r));
      default: wr_nxt = wr_r;
    endcase
    rd_nxt  = pop ? inc3(rd_r) : rd_r;
    cnt_nxt = cnt_r + n_in - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (n_in == 2'd2) begin
      mem_r[inc3(wr_r)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### sv/delimited_integer_list_parser.sv
// Delimited integer list parser: takes one text byte per beat and emits signed decimal
// values parsed atoi-style, split into groups and fields by the configured separator
// bytes, saturated to 32 bits. Each byte is parsed in the cycle it is accepted and its
// results are registered in a three-entry result queue. Sustained rate is one byte
// per cycle while the queue has room; a byte that gives two results (a separator on
// the final byte) presents them in turn, and the input stalls while the queue holds
// two or more results. Configuration is written one register per beat, ready always high;
// the user must write it only while the block is idle; the block does not enforce it.
module delimited_integer_list_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_text_byte,
  input  logic                           in_end_of_text,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_number,
  output logic                           out_number_valid,
  output logic                           out_group_done,
  output logic                           out_text_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [dilp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);
  import dilp_pkg::*;

  cfg_t       cfg_r;
  res_t       res0, res1, head;
  logic [1:0] res_cnt;
  logic       accept;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_sep <= GROUP_SEP_RST;
      cfg_r.field_sep <= FIELD_SEP_RST;
      cfg_r.split_en  <= 1'b1;
      cfg_r.m1_rule   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GROUP_SEP: cfg_r.group_sep <= cfg_data;
        CFG_FIELD_SEP: cfg_r.field_sep <= cfg_data;
        CFG_SPLIT_EN:  cfg_r.split_en  <= cfg_data[0];
        CFG_M1_RULE:   cfg_r.m1_rule   <= cfg_data[0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  dilp_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .cfg         (cfg_r),
    .res0        (res0),
    .res1        (res1),
    .res_cnt     (res_cnt)
  );

  dilp_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_cnt (res_cnt),
    .push0    (res0),
    .push1    (res1),
    .room     (in_ready),
    .q_valid  (out_valid),
    .q_ready  (out_ready),
    .q_head   (head)
  );

  assign out_number       = head.number;
  assign out_number_valid = head.number_valid;
  assign out_group_done   = head.group_done;
  assign out_text_done    = head.text_done;

endmodule

### sv/dilp_checker.sv
module dilp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [7:0]         in_text_byte,
  input logic               in_end_of_text,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_number,
  input logic               out_number_valid,
  input logic               out_group_done,
  input logic               out_text_done
);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_number)
      && $stable(out_text_done))
    else $error("stalled result beat changed");

  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_number_valid |-> out_text_done && !out_group_done
      && (out_number == 32'sd0))
    else $error("malformed end marker");

  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_done && out_number_valid |-> out_group_done)
    else $error("final value does not close its group");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_text_byte)
      && $stable(in_end_of_text))
    else $error("stalled input beat changed");

endmodule

bind delimited_integer_list_parser dilp_checker u_chk (.*);
